### sv/rcwb_pkg.sv
// ----------------------------------------------------------------------------
// rcwb_pkg
// Shared constants, codes and controller/datapath interface types for the
// read coverage window binner.
// ----------------------------------------------------------------------------
package rcwb_pkg;

    localparam longint GENOME_LEN_DEF = 64'd1048576;
    localparam int     READ_SPAN_DEF  = 100;
    localparam int     COUNT_BITS_DEF = 16;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 2;
    localparam int PADDR_W   = 3;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_SCAN  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [1:0] KIND_WINDOW = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [15:0] FLAG_FWD = 16'd0;
    localparam logic [15:0] FLAG_REV = 16'd16;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_WINDOW    = 1'b1;

    typedef struct packed {
        logic ready;
        logic load;
        logic clr_step;
        logic add_init;
        logic add_rd;
        logic sum_init;
        logic sum_rd;
        logic div_init;
        logic div_step;
        logic win_set;
        logic win_adv;
        logic finish;
        logic q_rd;
        logic res_err;
        logic res_win;
        logic res_query;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] mode;
        logic       flag_fwd;
        logic       flag_rev;
        logic       range_err;
        logic       cnt_zero;
        logic       at_end;
        logic       div_done;
        logic       e_beyond;
        logic       keep_win;
        logic       finished;
        logic       out_free;
    } status_t;

endpackage

### sv/rcwb_regs.sv
// ----------------------------------------------------------------------------
// rcwb_regs
// APB configuration registers: threshold and window size.
// ----------------------------------------------------------------------------
module rcwb_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rcwb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [31:0]                  threshold,
    output logic [15:0]                  win_len
);

    logic [31:0] threshold_reg;
    logic [15:0] window_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
            window_reg    <= 16'd1;
        end else if (wr_en) begin
            if (paddr[2] == rcwb_pkg::REG_THRESHOLD) begin
                threshold_reg <= pwdata;
            end else begin
                window_reg <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == rcwb_pkg::REG_THRESHOLD) begin
            prdata = threshold_reg;
        end else begin
            prdata = {16'd0, window_reg};
        end
    end

    assign threshold = threshold_reg;
    assign win_len   = window_reg;

endmodule

### sv/rcwb_ctrl.sv
// ----------------------------------------------------------------------------
// rcwb_ctrl
// Controller: sequences clearing, read adds, window scans and queries.
// ----------------------------------------------------------------------------
module rcwb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  rcwb_pkg::status_t st,
    output rcwb_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ADD,
        S_ADD_WB,
        S_DIV,
        S_WIN_CHK,
        S_SUM,
        S_SUM_TAIL,
        S_WIN_END,
        S_NEXT,
        S_QRY,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (st.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.ready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (st.mode == rcwb_pkg::MODE_ADD) begin
                    if (!(st.flag_fwd || st.flag_rev)) begin
                        state_next = S_IDLE;
                    end else if (st.range_err) begin
                        cmd.res_err = 1'b1;
                        state_next  = S_EMIT;
                    end else begin
                        cmd.add_init = 1'b1;
                        state_next   = S_ADD;
                    end
                end else if (st.mode == rcwb_pkg::MODE_SCAN) begin
                    if (st.finished) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.div_init = 1'b1;
                        state_next   = S_DIV;
                    end
                end else if (st.mode == rcwb_pkg::MODE_QUERY) begin
                    cmd.q_rd   = 1'b1;
                    state_next = S_QRY;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_ADD: begin
                cmd.add_rd = 1'b1;
                if (st.cnt_zero) begin
                    state_next = S_ADD_WB;
                end
            end
            S_ADD_WB: begin
                state_next = S_IDLE;
            end
            S_DIV: begin
                if (st.div_done) begin
                    cmd.win_set = 1'b1;
                    state_next  = S_WIN_CHK;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_WIN_CHK: begin
                if (st.e_beyond) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    cmd.sum_init = 1'b1;
                    state_next   = S_SUM;
                end
            end
            S_SUM: begin
                cmd.sum_rd = 1'b1;
                if (st.at_end) begin
                    state_next = S_SUM_TAIL;
                end
            end
            S_SUM_TAIL: begin
                state_next = S_WIN_END;
            end
            S_WIN_END: begin
                cmd.win_adv = 1'b1;
                if (st.keep_win) begin
                    cmd.res_win = 1'b1;
                    state_next  = S_EMIT;
                end else begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_QRY: begin
                cmd.res_query = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT: begin
                if (st.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### sv/rcwb_dp.sv
// ----------------------------------------------------------------------------
// rcwb_dp
// Datapath: coverage memory, add read-modify-write pipe, window divider and
// accumulator, query read, result and output registers.
// ----------------------------------------------------------------------------
module rcwb_dp #(
    parameter longint GENOME_LEN = rcwb_pkg::GENOME_LEN_DEF,
    parameter int     READ_SPAN  = rcwb_pkg::READ_SPAN_DEF,
    parameter int     COUNT_BITS = rcwb_pkg::COUNT_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rcwb_pkg::cmd_t                 cmd,
    output rcwb_pkg::status_t              st,
    input  logic [rcwb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [rcwb_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic [31:0]                    threshold,
    input  logic [15:0]                    win_len,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rcwb_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [rcwb_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                           m_tlast
);

    localparam int ADDR_W = $clog2(GENOME_LEN);
    localparam int POS_W  = ADDR_W + 1;
    localparam int EW     = ((POS_W > 17) ? POS_W : 17) + 1;
    localparam int CNT_W  = $clog2(READ_SPAN + 1);
    localparam int DCNT_W = $clog2(POS_W + 1);

    localparam logic [33:0]       LEN34  = 34'(GENOME_LEN);
    localparam logic [33:0]       SPAN34 = 34'(READ_SPAN);
    localparam logic [EW:0]       LEN_E  = (EW + 1)'(GENOME_LEN);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(GENOME_LEN - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] cov_mem [GENOME_LEN];

    logic [1:0]            mode_reg;
    logic [15:0]           flag_reg;
    logic [31:0]           pos_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [ADDR_W-1:0]     wb_addr_reg;
    logic                  wb_pend_reg;
    logic                  acc_pend_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [COUNT_BITS-1:0] dout_reg;
    logic [POS_W-1:0]      cursor_reg;
    logic                  finished_reg;
    logic [POS_W-1:0]      div_d_reg;
    logic [15:0]           rem_reg;
    logic [DCNT_W-1:0]     div_cnt_reg;
    logic [EW-1:0]         e_reg;
    logic [31:0]           sum_reg;
    logic [1:0]            res_kind_reg;
    logic [31:0]           res_where_reg;
    logic [31:0]           res_total_reg;
    logic                  res_last_reg;
    logic                  m_valid_reg;
    logic [1:0]            m_kind_reg;
    logic [31:0]           m_where_reg;
    logic [31:0]           m_total_reg;
    logic                  m_last_reg;

    logic [33:0]       pos_x;
    logic [33:0]       lo_x;
    logic              flag_fwd;
    logic              flag_rev;
    logic              fwd_err;
    logic              rev_err;
    logic              q_in_range;
    logic [16:0]       w_eff;
    logic [16:0]       div_tmp;
    logic [EW-1:0]     e_calc;
    logic [EW:0]       e_plus_w;
    logic              last_c;
    logic [32:0]       sum_add;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    assign pos_x      = {2'b00, pos_reg};
    assign flag_fwd   = (flag_reg == rcwb_pkg::FLAG_FWD);
    assign flag_rev   = (flag_reg == rcwb_pkg::FLAG_REV);
    assign fwd_err    = (pos_x + SPAN34) >= LEN34;
    assign rev_err    = (pos_x < SPAN34) || (pos_x >= LEN34);
    assign lo_x       = flag_fwd ? pos_x : (pos_x - SPAN34);
    assign q_in_range = pos_x < LEN34;

    assign w_eff   = (win_len == 16'd0) ? 17'd1 : {1'b0, win_len};
    assign div_tmp = {rem_reg, div_d_reg[POS_W-1]};
    assign e_calc  = (cursor_reg == '0) ? '0
                   : (EW'(cursor_reg) - EW'(1) - EW'(rem_reg) + EW'(w_eff));
    assign e_plus_w = {1'b0, e_reg} + (EW + 1)'(w_eff);
    assign last_c   = e_plus_w >= LEN_E;
    assign sum_add  = {1'b0, sum_reg} + 33'(dout_reg);

    assign st.clr_last  = (addr_reg == ADDR_LAST);
    assign st.mode      = mode_reg;
    assign st.flag_fwd  = flag_fwd;
    assign st.flag_rev  = flag_rev;
    assign st.range_err = flag_fwd ? fwd_err : rev_err;
    assign st.cnt_zero  = (cnt_reg == '0);
    assign st.at_end    = (addr_reg == e_reg[ADDR_W-1:0]);
    assign st.div_done  = (div_cnt_reg == '0);
    assign st.e_beyond  = {1'b0, e_reg} >= LEN_E;
    assign st.keep_win  = (sum_reg != '0) || last_c;
    assign st.finished  = finished_reg;
    assign st.out_free  = !m_valid_reg || m_tready;

    // memory ports
    assign rd_addr = cmd.q_rd ? pos_reg[ADDR_W-1:0] : addr_reg;
    assign mem_we  = cmd.clr_step || wb_pend_reg;
    assign wr_addr = cmd.clr_step ? addr_reg : wb_addr_reg;
    assign wr_data = cmd.clr_step ? '0
                   : ((dout_reg == COUNT_MAX) ? dout_reg : dout_reg + 1'b1);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cov_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        dout_reg <= cov_mem[rd_addr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg     <= '0;
            wb_pend_reg  <= 1'b0;
            acc_pend_reg <= 1'b0;
            cursor_reg   <= '0;
            finished_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            wb_pend_reg  <= cmd.add_rd;
            acc_pend_reg <= cmd.sum_rd;
            if (cmd.clr_step || cmd.add_rd || cmd.sum_rd) begin
                addr_reg <= addr_reg + 1'b1;
            end else if (cmd.add_init) begin
                addr_reg <= lo_x[ADDR_W-1:0];
            end else if (cmd.sum_init) begin
                addr_reg <= cursor_reg[ADDR_W-1:0];
            end
            if (cmd.win_adv) begin
                cursor_reg <= e_reg[POS_W-1:0] + 1'b1;
            end
            if (cmd.finish || (cmd.win_adv && last_c)) begin
                finished_reg <= 1'b1;
            end
            if (cmd.push) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= s_tuser;
            flag_reg <= s_tdata[15:0];
            pos_reg  <= s_tdata[47:16];
        end
        if (cmd.add_rd) begin
            wb_addr_reg <= addr_reg;
        end
        if (cmd.add_init) begin
            cnt_reg <= CNT_W'(READ_SPAN);
        end else if (cmd.add_rd) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.div_init) begin
            div_d_reg   <= cursor_reg - 1'b1;
            rem_reg     <= '0;
            div_cnt_reg <= DCNT_W'(POS_W);
        end else if (cmd.div_step) begin
            div_d_reg   <= div_d_reg << 1;
            div_cnt_reg <= div_cnt_reg - 1'b1;
            if (div_tmp >= w_eff) begin
                rem_reg <= 16'(div_tmp - w_eff);
            end else begin
                rem_reg <= div_tmp[15:0];
            end
        end
        if (cmd.win_set) begin
            e_reg <= e_calc;
        end
        if (cmd.sum_init) begin
            sum_reg <= '0;
        end else if (acc_pend_reg) begin
            sum_reg <= sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
        end
        priority if (cmd.res_err) begin
            res_kind_reg  <= rcwb_pkg::KIND_ERROR;
            res_where_reg <= pos_reg;
            res_total_reg <= '0;
            res_last_reg  <= 1'b0;
        end else if (cmd.res_win) begin
            res_kind_reg  <= rcwb_pkg::KIND_WINDOW;
            res_where_reg <= 32'(e_reg);
            res_total_reg <= (sum_reg > threshold) ? sum_reg : '0;
            res_last_reg  <= last_c;
        end else if (cmd.res_query) begin
            res_kind_reg  <= rcwb_pkg::KIND_QUERY;
            res_where_reg <= pos_reg;
            res_total_reg <= q_in_range ? 32'(dout_reg) : '0;
            res_last_reg  <= 1'b0;
        end
        if (cmd.push) begin
            m_kind_reg  <= res_kind_reg;
            m_where_reg <= res_where_reg;
            m_total_reg <= res_total_reg;
            m_last_reg  <= res_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_total_reg, m_where_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

### sv/read_coverage_window_binner_core.sv
// ----------------------------------------------------------------------------
// read_coverage_window_binner_core
// Coverage histogram over aligned reads with binned window reports.
//
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  tuser: mode; tdata: read_flag, position
// m_       out  m_tvalid/m_tready  tuser: kind; tdata: where, total; tlast
// apb      in   psel/penable       threshold @0x0, win_len @0x4
//
// After reset a clearing pass zeroes the coverage memory, with s_tready
// low; configuration writes are taken meanwhile. Add: one counter
// read-modify-write per cycle on the memory's read and write ports.
// Scan: each window visited is found by a divider pass and then summed by
// an accumulate pass over its counters; empty windows are walked within
// the same transaction. A finished result waits in the output register;
// the next transaction is taken meanwhile and stalls only when it must
// emit into a full register.
// ----------------------------------------------------------------------------
module read_coverage_window_binner_core #(
    parameter longint GENOME_LEN = rcwb_pkg::GENOME_LEN_DEF,
    parameter int     READ_SPAN  = rcwb_pkg::READ_SPAN_DEF,
    parameter int     COUNT_BITS = rcwb_pkg::COUNT_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rcwb_pkg::S_TDATA_W-1:0] s_tdata,  // read_flag[15:0], position[47:16]
    input  logic [rcwb_pkg::S_TUSER_W-1:0] s_tuser,  // mode[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rcwb_pkg::M_TDATA_W-1:0] m_tdata,  // where[31:0], total[63:32]
    output logic [rcwb_pkg::M_TUSER_W-1:0] m_tuser,  // kind[1:0]
    output logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rcwb_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    rcwb_pkg::cmd_t    cmd;
    rcwb_pkg::status_t st;
    logic [31:0]       threshold;
    logic [15:0]       win_len;

    rcwb_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .threshold (threshold),
        .win_len   (win_len)
    );

    rcwb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .st       (st),
        .cmd      (cmd)
    );

    rcwb_dp #(
        .GENOME_LEN (GENOME_LEN),
        .READ_SPAN  (READ_SPAN),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .threshold (threshold),
        .win_len   (win_len),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    assign s_tready = cmd.ready;

endmodule

### sv/rcwb_checker.sv
// ----------------------------------------------------------------------------
// rcwb_checker
// Port-level checks for the read coverage window binner, bound to the core.
// ----------------------------------------------------------------------------
module rcwb_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rcwb_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [rcwb_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                           m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_clear_after_reset: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !s_tready)
        else $error("input taken before memory clear");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while one is in work");

    a_last_window_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == rcwb_pkg::KIND_WINDOW)
        else $error("last flag on a non-window result");

    a_error_total_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rcwb_pkg::KIND_ERROR |-> m_tdata[63:32] == 32'd0)
        else $error("span error result with nonzero total");

endmodule

bind read_coverage_window_binner_core rcwb_checker u_rcwb_checker (.*);

### sim/tb_read_coverage_window_binner_core.sv
// ----------------------------------------------------------------------------
// tb_read_coverage_window_binner_core
// Self-checking bench for the read coverage window binner. Streams add, scan
// and query transactions with random idle on both channels, keeps its own
// coverage histogram and scan position, and checks every report field by
// field in order. Register settings change between phases; the run ends with
// one of three ways of finishing the scan near the end of the store.
// ----------------------------------------------------------------------------
module tb_read_coverage_window_binner_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rcwb_pkg::*;

    localparam longint GLEN         = GENOME_LEN_DEF;
    localparam int     SPAN         = READ_SPAN_DEF;
    localparam int     COVER_HI     = 4096;
    localparam longint SCAN_CAP     = 6000;
    localparam longint DIV_OVERHEAD = 40;
    localparam longint NO_CAP       = 64'h4000_0000_0000_0000;
    localparam int     SETTLE       = 150;

    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam logic [31:0] LAST_FWD    = 32'(GLEN - SPAN - 1);
    localparam logic [31:0] LAST_POS    = 32'(GLEN - 1);
    localparam logic [31:0] PAST_END    = 32'(GLEN);
    localparam logic [31:0] MID_READ    = 32'd989950;

    // window sizes for the closing scan
    localparam logic [15:0] WIN_WIDEST  = 16'hFFFF;
    localparam logic [15:0] WIN_EMPTY_LAST = 16'd40000;
    localparam logic [15:0] WIN_TO_MID  = 16'd30000;
    localparam longint      MID_WIN_END = 990000;
    localparam logic [15:0] WIN_NO_END  = 16'd61681;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] flag;
        logic [31:0] pos;
    } read_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] locus;
        logic [31:0] total;
        logic        last_win;
    } report_t;

    class coverage_tracker;
        bit [15:0]   depth [0:GLEN-1];
        longint      cursor;
        bit          finished;
        logic [31:0] threshold;
        logic [15:0] win_size;
        report_t     awaited [$];
        int          errors;

        function new();
            cursor    = 0;
            finished  = 1'b0;
            threshold = '0;
            win_size  = 16'd1;
            errors    = 0;
        endfunction

        function void bump(longint lo, longint hi);
            longint p;
            for (p = lo; p <= hi; p++) begin
                if (depth[p] != 16'hFFFF) depth[p]++;
            end
        endfunction

        function bit walk_windows(bit commit, longint cap, output report_t rep,
                                  output bit emits);
            longint w, s, e, sum, cost, cur, p;
            bit     fin, is_last, known;
            w     = (win_size == 0) ? 1 : win_size;
            cur   = cursor;
            fin   = finished;
            cost  = 0;
            known = 1'b1;
            emits = 1'b0;
            rep   = '0;
            while (!fin && !emits && known) begin
                s = cur;
                e = (s == 0) ? 0 : ((s + w - 1) / w) * w;
                cost += e - s + 1 + DIV_OVERHEAD;
                if (e >= GLEN) begin
                    fin = 1'b1;
                end else if (cost > cap) begin
                    known = 1'b0;
                end else begin
                    sum = 0;
                    for (p = s; p <= e; p++) sum += depth[p];
                    cur     = e + 1;
                    is_last = (e + w >= GLEN);
                    if (is_last) fin = 1'b1;
                    if (sum != 0 || is_last) begin
                        if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
                        rep.kind     = KIND_WINDOW;
                        rep.locus    = e[31:0];
                        rep.total    = (sum <= threshold) ? 32'd0 : sum[31:0];
                        rep.last_win = is_last;
                        emits        = 1'b1;
                    end
                end
            end
            if (commit && known) begin
                cursor   = cur;
                finished = fin;
            end
            return known;
        endfunction

        function void take_read_item(read_item_t it);
            longint  st;
            report_t rep;
            bit      emits;
            st    = longint'(it.pos);
            rep   = '0;
            emits = 1'b0;
            case (it.mode)
                MODE_ADD: begin
                    if (it.flag == FLAG_FWD) begin
                        if (st + SPAN >= GLEN) emits = 1'b1;
                        else bump(st, st + SPAN);
                    end else if (it.flag == FLAG_REV) begin
                        if (st < SPAN || st >= GLEN) emits = 1'b1;
                        else bump(st - SPAN, st);
                    end
                    if (emits) begin
                        rep.kind  = KIND_ERROR;
                        rep.locus = it.pos;
                    end
                end
                MODE_SCAN: begin
                    void'(walk_windows(1'b1, NO_CAP, rep, emits));
                end
                MODE_QUERY: begin
                    emits     = 1'b1;
                    rep.kind  = KIND_QUERY;
                    rep.locus = it.pos;
                    rep.total = (st < GLEN) ? depth[st] : 32'd0;
                end
                default: ;
            endcase
            if (emits) awaited.push_back(rep);
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_report(logic [1:0] kind, logic [31:0] locus,
                                   logic [31:0] total, logic last_win);
            report_t want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: report expected none actual kind %0d at %0d total %0d",
                         $time, kind, locus, total);
                return;
            end
            want = awaited.pop_front();
            match_field("kind", want.kind, kind);
            match_field("where", want.locus, locus);
            match_field("total", want.total, total);
            match_field("last_window", want.last_win, last_win);
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    coverage_tracker tracker = new();
    bit              tx_steady = 1'b0;
    bit              rx_steady = 1'b0;
    int              rx_hold   = 0;

    read_coverage_window_binner_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
            tracker.check_report(m_tuser, m_tdata[31:0], m_tdata[63:32], m_tlast);
            if ($urandom_range(0, 29) == 0) rx_steady = !rx_steady;
            rx_hold = rx_steady ? 0 : $urandom_range(0, 7);
        end
        if (rx_hold != 0) begin
            m_tready <= 1'b0;
            if (m_tvalid === 1'b1) rx_hold--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send(input logic [1:0] mode, input logic [15:0] flag,
                        input logic [31:0] pos);
        int         gap;
        read_item_t it;
        it.mode = mode;
        it.flag = flag;
        it.pos  = pos;
        if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pos, flag};
        s_tuser  <= mode;
        do @(posedge aclk); while (s_tready !== 1'b1);
        tracker.take_read_item(it);
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_THRESHOLD) tracker.threshold = value;
        else tracker.win_size = value[15:0];
        @(posedge aclk);
    endtask

    task automatic program_regs(input logic [31:0] thr, input logic [15:0] wsize);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_WINDOW, {16'd0, wsize});
    endtask

    task automatic send_random();
        int      pick;
        report_t probe;
        bit      emits;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send(MODE_ADD, FLAG_FWD, $urandom_range(0, COVER_HI));
        end else if (pick < 52) begin
            send(MODE_ADD, FLAG_REV, $urandom_range(SPAN, COVER_HI + SPAN));
        end else if (pick < 57) begin
            send(MODE_ADD, $urandom_range(0, 1) ? FLAG_FWD : FLAG_REV, $urandom());
        end else if (pick < 61) begin
            send(MODE_ADD, 16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, COVER_HI));
        end else if (pick < 76 && tracker.walk_windows(1'b0, SCAN_CAP, probe, emits)
                     && emits && !probe.last_win) begin
            send(MODE_SCAN, 16'($urandom()), $urandom());
        end else if (pick < 96) begin
            send(MODE_QUERY, 16'($urandom()), ($urandom_range(0, 4) == 0) ? $urandom()
                 : $urandom_range(0, COVER_HI + SPAN));
        end else begin
            send(MODE_UNUSED, 16'($urandom()), $urandom());
        end
    endtask

    initial begin
        int seg;
        int variant;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        program_regs(32'd0, 16'd1);

        send(MODE_ADD, FLAG_FWD, 32'd0);
        send(MODE_ADD, FLAG_REV, SPAN);
        send(MODE_ADD, FLAG_REV, SPAN - 1);
        send(MODE_ADD, FLAG_FWD, LAST_FWD);
        send(MODE_ADD, FLAG_FWD, LAST_FWD + 1);
        send(MODE_ADD, FLAG_REV, LAST_POS);
        send(MODE_ADD, FLAG_REV, PAST_END);
        send(MODE_ADD, FLAG_FWD, 32'hFFFF_FFFF);
        send(MODE_ADD, FLAG_REV, 32'hFFFF_FFFF);
        send(MODE_ADD, 16'hFFFF, 32'd50);
        send(MODE_ADD, 16'h0001, 32'd50);
        send(MODE_ADD, FLAG_FWD, MID_READ);
        send(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        send(MODE_QUERY, 16'd0, 32'd0);
        send(MODE_QUERY, 16'd0, SPAN);
        send(MODE_QUERY, 16'd0, SPAN + 1);
        send(MODE_QUERY, 16'd0, LAST_POS);
        send(MODE_QUERY, 16'd0, PAST_END);
        send(MODE_QUERY, 16'hFFFF, 32'hFFFF_FFFF);
        send(MODE_SCAN, 16'd0, 32'd0);
        send(MODE_SCAN, 16'd0, 32'd0);
        quiesce();
        program_regs(32'd2, 16'd1);
        send(MODE_SCAN, 16'd0, 32'd0);
        send(MODE_QUERY, 16'd0, 32'd50);

        for (seg = 0; seg < 5; seg++) begin
            quiesce();
            case (seg)
                0: program_regs(32'd0, 16'd1);
                1: program_regs($urandom_range(1, 400), 16'($urandom_range(2, 64)));
                2: program_regs(32'hFFFF_FFFF, 16'd0);
                3: program_regs($urandom_range(0, 3000), 16'($urandom_range(65, 400)));
                default: program_regs($urandom_range(0, 200), 16'($urandom_range(1, 16)));
            endcase
            repeat (100) send_random();
        end

        // finish the scan: widest window, empty final window, or no window end left
        quiesce();
        variant = $urandom_range(0, 2);
        case (variant)
            0: program_regs($urandom_range(0, 50), WIN_WIDEST);
            1: program_regs($urandom_range(0, 50), WIN_EMPTY_LAST);
            default: program_regs($urandom_range(0, 50), WIN_TO_MID);
        endcase
        while (!tracker.finished && !(variant == 2 && tracker.cursor > MID_WIN_END))
            send(MODE_SCAN, 16'($urandom()), $urandom());
        if (variant == 2) begin
            quiesce();
            program_regs($urandom_range(0, 50), WIN_NO_END);
        end
        repeat (3) send(MODE_SCAN, 16'($urandom()), $urandom());
        send(MODE_QUERY, 16'd0, MID_READ);
        quiesce();

        if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
            $display("PASS read_coverage_window_binner_core");
        end else begin
            $display("FAIL read_coverage_window_binner_core");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("FAIL read_coverage_window_binner_core");
        $finish;
    end

endmodule
